>>> hdl/key_debounce_press_events_top_macros.svh
// -----------------------------------------------------------------------------
// Key debounce assertion macros
// Shared concurrent assertion forms for the key debounce checkers.
// -----------------------------------------------------------------------------
`ifndef KEY_DEBOUNCE_PRESS_EVENTS_TOP_MACROS_SVH
`define KEY_DEBOUNCE_PRESS_EVENTS_TOP_MACROS_SVH

// Checked on the rising clock edge, disabled while reset is asserted.
`define KDPE_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("key debounce assertion failed");

// Same check with a message chosen by the caller.
`define KDPE_ASSERT_MSG(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error(msg);

`endif

>>> hdl/kdpe_pkg.sv
// -----------------------------------------------------------------------------
// Key debounce package
// Widths, register indexes, reset values and types of the key debouncer.
// -----------------------------------------------------------------------------
package kdpe_pkg;

  localparam int KEY_W       = 8;
  localparam int CNT_W       = 8;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 8;
  localparam int NUM_KEYS_DEF = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SHORT_RELEASE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COUNT_CEILING = 2'd2;

  localparam logic [CNT_W-1:0] LONG_PRESS_RST    = 8'd40;
  localparam logic [CNT_W-1:0] SHORT_RELEASE_RST = 8'd100;
  localparam logic [CNT_W-1:0] COUNT_CEILING_RST = 8'd201;

  typedef enum logic [2:0] {
    PH_CAPTURE = 3'b001,
    PH_CHECK1  = 3'b010,
    PH_CHECK2  = 3'b100
  } phase_e;

  // Packed so that debounced_keys sits in the lowest bits.
  typedef struct packed {
    logic [KEY_W-1:0] long_press_events;
    logic [KEY_W-1:0] short_release_events;
    logic [KEY_W-1:0] debounced_keys;
  } result_t;

endpackage

>>> hdl/key_debounce_press_events_top.sv
// -----------------------------------------------------------------------------
// Key debounce with short release and long press events
// Debounces a scanned key vector and tracks per-key hold counters.
// -----------------------------------------------------------------------------
//
// Channel   Direction  Handshake                 Payload
// s_axis    in         s_axis_tvalid/tready      tdata[7:0]   raw_keys
// m_axis    out        m_axis_tvalid/tready      tdata[23:0]  debounced, short, long
// cfg       in         cfg_valid_i/cfg_ready_o   cfg_index_i, cfg_data_i
//
// Each item's result is valid in the output register in the cycle after its
// acceptance; a new item can be accepted every cycle unless the input stalls.
// The output register frees in the same cycle that its result is taken, so the
// input stalls only while a result waits and the output side is not ready.
// Reset clears the debouncer, all hold state and loads the default registers.
// Configuration writes are always taken (cfg_ready_o is tied high).
module key_debounce_press_events_top #(
  parameter int NUM_KEYS = kdpe_pkg::NUM_KEYS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [kdpe_pkg::KEY_W-1:0]        s_axis_tdata,   // [7:0] raw_keys
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [7:0] debounced_keys, [15:8] short_release_events, [23:16] long_press_events
  output logic [3*kdpe_pkg::KEY_W-1:0]      m_axis_tdata,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [kdpe_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [kdpe_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  localparam int KW = kdpe_pkg::KEY_W;
  localparam int CW = kdpe_pkg::CNT_W;

  kdpe_pkg::phase_e  phase_q, phase_d;
  logic [KW-1:0]     cand_q, cand_d;
  logic [KW-1:0]     conf_q, conf_d;
  logic              held_q  [NUM_KEYS];
  logic              held_d  [NUM_KEYS];
  logic [CW-1:0]     count_q [NUM_KEYS];
  logic [CW-1:0]     count_d [NUM_KEYS];
  logic [CW-1:0]     long_q, short_q, ceil_q;
  logic              out_valid_q;
  kdpe_pkg::result_t out_q, result;

  logic          accept;
  logic          published;
  logic          changed;
  logic [KW-1:0] raw;
  logic [KW-1:0] short_ev;
  logic [KW-1:0] long_ev;

  assign raw           = s_axis_tdata;
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;

  always_comb begin
    phase_d   = phase_q;
    cand_d    = cand_q;
    published = 1'b0;
    unique case (phase_q)
      kdpe_pkg::PH_CAPTURE: begin
        cand_d  = raw;
        phase_d = kdpe_pkg::PH_CHECK1;
      end
      kdpe_pkg::PH_CHECK1: begin
        if (cand_q == raw) begin
          phase_d = kdpe_pkg::PH_CHECK2;
        end else begin
          cand_d  = '0;
          phase_d = kdpe_pkg::PH_CAPTURE;
        end
      end
      kdpe_pkg::PH_CHECK2: begin
        phase_d   = kdpe_pkg::PH_CAPTURE;
        published = (cand_q == raw);
        cand_d    = '0;
      end
      default: begin
        phase_d = kdpe_pkg::PH_CAPTURE;
      end
    endcase
  end

  assign conf_d  = published ? raw : conf_q;
  assign changed = published && (raw != conf_q);

  for (genvar i = 0; i < NUM_KEYS; i++) begin : g_key
    logic          held_mid;
    logic [CW-1:0] count_mid;
    logic [CW:0]   count_inc;

    always_comb begin
      held_mid    = held_q[i];
      count_mid   = count_q[i];
      short_ev[i] = 1'b0;
      if (changed) begin
        if (raw[i]) begin
          if (count_q[i] == '0) begin
            held_mid = 1'b1;
          end
        end else if (held_q[i]) begin
          short_ev[i] = (count_q[i] != '0) && (count_q[i] <= short_q);
          held_mid    = 1'b0;
          count_mid   = '0;
        end
      end
    end

    assign count_inc = {1'b0, count_mid} + {{CW{1'b0}}, 1'b1};

    always_comb begin
      long_ev[i] = 1'b0;
      held_d[i]  = held_mid;
      count_d[i] = '0;
      if (held_mid) begin
        if (count_inc == {1'b0, long_q}) begin
          long_ev[i] = 1'b1;
          count_d[i] = count_inc[CW-1:0];
        end else if (count_inc >= {1'b0, ceil_q}) begin
          count_d[i] = ceil_q;
        end else begin
          count_d[i] = count_inc[CW-1:0];
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        held_q[i]  <= 1'b0;
        count_q[i] <= '0;
      end else if (accept) begin
        held_q[i]  <= held_d[i];
        count_q[i] <= count_d[i];
      end
    end
  end

  for (genvar j = NUM_KEYS; j < KW; j++) begin : g_unused
    assign short_ev[j] = 1'b0;
    assign long_ev[j]  = 1'b0;
  end

  assign result.debounced_keys       = conf_d;
  assign result.short_release_events = short_ev;
  assign result.long_press_events    = long_ev;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= kdpe_pkg::PH_CAPTURE;
      cand_q      <= '0;
      conf_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        phase_q <= phase_d;
        cand_q  <= cand_d;
        conf_q  <= conf_d;
      end
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_q <= result;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      long_q  <= kdpe_pkg::LONG_PRESS_RST;
      short_q <= kdpe_pkg::SHORT_RELEASE_RST;
      ceil_q  <= kdpe_pkg::COUNT_CEILING_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        kdpe_pkg::CFG_LONG_PRESS:    long_q  <= cfg_data_i;
        kdpe_pkg::CFG_SHORT_RELEASE: short_q <= cfg_data_i;
        kdpe_pkg::CFG_COUNT_CEILING: ceil_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

endmodule

>>> hdl/kdpe_checker.sv
// -----------------------------------------------------------------------------
// Key debounce port checker
// Checks result consistency and output stalls on the top level ports.
// -----------------------------------------------------------------------------
`include "key_debounce_press_events_top_macros.svh"

module kdpe_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              s_axis_tready,
  input logic                              m_axis_tvalid,
  input logic                              m_axis_tready,
  input logic [3*kdpe_pkg::KEY_W-1:0]      m_axis_tdata
);

  kdpe_pkg::result_t res;
  assign res = m_axis_tdata;

  // A waiting result must hold until it is taken.
  `KDPE_ASSERT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))

  // An empty output register never stalls the input.
  `KDPE_ASSERT_MSG(a_in_ready, clk_i, rst_ni, !m_axis_tvalid |-> s_axis_tready, "input stalled while output empty")

  // A short release belongs to a released key, a long press to a pressed one.
  `KDPE_ASSERT(a_short_released, clk_i, rst_ni, m_axis_tvalid |-> (res.short_release_events & res.debounced_keys) == '0)

  `KDPE_ASSERT(a_long_pressed, clk_i, rst_ni, m_axis_tvalid |-> (res.long_press_events & ~res.debounced_keys) == '0)

endmodule

bind key_debounce_press_events_top kdpe_checker u_kdpe_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

>>> sim/key_debounce_press_events_top_test.sv
// -----------------------------------------------------------------------------
// Key debounce press events testbench
// Drives scan ticks into the key debouncer under random handshake gaps and
// checks every result against a cycle-free model of the debouncer and of the
// per-key hold counters. A short table of directed ticks comes first, then
// random runs of stable key vectors mixed with noise, under several register
// settings, the extremes among them.
// -----------------------------------------------------------------------------
module key_debounce_press_events_top_test;
  import kdpe_pkg::*;

  localparam int NKEYS       = NUM_KEYS_DEF;
  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASE_TICKS = 190;

  typedef enum logic [1:0] {
    DB_CAPTURE = 2'd0,
    DB_CHECK1  = 2'd1,
    DB_CHECK2  = 2'd2,
    DB_SPARE   = 2'd3
  } db_phase_e;

  typedef struct packed {
    logic [KEY_W-1:0] raw;
    logic             typed;
    result_t          want;
  } tick_row_t;

  typedef struct packed {
    logic [CNT_W-1:0] long_thr;
    logic [CNT_W-1:0] short_max;
    logic [CNT_W-1:0] ceiling;
    logic             long_first;
  } reg_set_t;

  localparam tick_row_t DIRECTED [0:22] = '{
    '{8'h00, 1'b1, 24'h000000}, '{8'h00, 1'b1, 24'h000000}, '{8'h00, 1'b1, 24'h000000},
    '{8'hFF, 1'b1, 24'h000000}, '{8'hFF, 1'b1, 24'h000000}, '{8'hFF, 1'b1, 24'h0000FF},
    '{8'h00, 1'b0, 24'h000000}, '{8'h00, 1'b0, 24'h000000}, '{8'h00, 1'b0, 24'h000000},
    '{8'h0F, 1'b0, 24'h000000}, '{8'hF0, 1'b0, 24'h000000},
    '{8'h0F, 1'b0, 24'h000000}, '{8'h0F, 1'b0, 24'h000000}, '{8'hF0, 1'b0, 24'h000000},
    '{8'hA5, 1'b0, 24'h000000}, '{8'hA5, 1'b0, 24'h000000}, '{8'hA5, 1'b0, 24'h000000},
    '{8'h5A, 1'b0, 24'h000000}, '{8'h5A, 1'b0, 24'h000000}, '{8'h5A, 1'b0, 24'h000000},
    '{8'h00, 1'b0, 24'h000000}, '{8'h00, 1'b0, 24'h000000}, '{8'h00, 1'b0, 24'h000000}
  };

  localparam reg_set_t REG_SETS [0:6] = '{
    '{8'd3,   8'd5,   8'd8,   1'b0},
    '{8'd255, 8'd255, 8'd255, 1'b1},
    '{8'd1,   8'd1,   8'd1,   1'b0},
    '{8'd6,   8'd4,   8'd5,   1'b0},
    '{8'd0,   8'd0,   8'd0,   1'b0},
    '{8'd40,  8'd100, 8'd201, 1'b0},
    '{8'd1,   8'd255, 8'd255, 1'b0}
  };

  logic                    clk_i;
  logic                    rst_ni;
  logic                    s_axis_tvalid;
  logic                    s_axis_tready;
  logic [KEY_W-1:0]        s_axis_tdata;
  logic                    m_axis_tvalid;
  logic                    m_axis_tready;
  logic [3*KEY_W-1:0]      m_axis_tdata;
  logic                    cfg_valid_i;
  logic                    cfg_ready_o;
  logic [CFG_IDX_W-1:0]    cfg_index_i;
  logic [CFG_DATA_W-1:0]   cfg_data_i;

  db_phase_e        pr_phase;
  logic [KEY_W-1:0] pr_candidate;
  logic [KEY_W-1:0] pr_confirmed;
  logic [KEY_W-1:0] pr_held;
  logic [CNT_W-1:0] pr_count [NKEYS];
  logic [CNT_W-1:0] pr_long_thr;
  logic [CNT_W-1:0] pr_short_max;
  logic [CNT_W-1:0] pr_ceiling;

  result_t pending_results [$];
  int      ticks_sent   = 0;
  int      results_seen = 0;
  int      error_count  = 0;
  int      cycle_count  = 0;
  int      rx_idle_pct  = 49;
  logic    rx_hold_off;

  key_debounce_press_events_top #(
    .NUM_KEYS(NKEYS)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic result_t debounce_step(input logic [KEY_W-1:0] raw);
    result_t          r;
    logic             published;
    logic [KEY_W-1:0] sample;
    logic [CNT_W:0]   nxt;
    r         = '0;
    published = 1'b0;
    sample    = '0;
    case (pr_phase)
      DB_CAPTURE: begin
        pr_candidate = raw;
        pr_phase     = DB_CHECK1;
      end
      DB_CHECK1: begin
        if (pr_candidate == raw) begin
          pr_phase = DB_CHECK2;
        end else begin
          pr_candidate = '0;
          pr_phase     = DB_CAPTURE;
        end
      end
      DB_CHECK2: begin
        pr_phase = DB_CAPTURE;
        if (pr_candidate == raw) begin
          sample    = pr_candidate;
          published = 1'b1;
        end
        pr_candidate = '0;
      end
      default: begin
        pr_phase = DB_CAPTURE;
      end
    endcase
    if (published) begin
      if (sample != pr_confirmed) begin
        for (int i = 0; i < NKEYS; i++) begin
          if (sample[i]) begin
            if (pr_count[i] == '0) pr_held[i] = 1'b1;
          end else if (pr_held[i]) begin
            if (pr_count[i] >= 1 && pr_count[i] <= pr_short_max)
              r.short_release_events[i] = 1'b1;
            pr_held[i]  = 1'b0;
            pr_count[i] = '0;
          end
        end
      end
      pr_confirmed = sample;
    end
    for (int i = 0; i < NKEYS; i++) begin
      if (pr_held[i]) begin
        nxt = {1'b0, pr_count[i]} + 1'b1;
        if (nxt == {1'b0, pr_long_thr}) begin
          r.long_press_events[i] = 1'b1;
        end else if (nxt >= {1'b0, pr_ceiling}) begin
          nxt = {1'b0, pr_ceiling};
        end
        pr_count[i] = nxt[CNT_W-1:0];
      end else begin
        pr_count[i] = '0;
      end
    end
    r.debounced_keys = pr_confirmed;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [KEY_W-1:0] want_v,
                                 input logic [KEY_W-1:0] got_v);
    $display("mismatch in %s at result %0d: expected %02h, got %02h",
             what, results_seen, want_v, got_v);
    error_count++;
  endtask

  task automatic send_tick(input logic [KEY_W-1:0] raw, input logic typed,
                           input result_t want);
    result_t predicted;
    int      tx_pct;
    tx_pct      = (ticks_sent < 560) ? 13 : (ticks_sent < 1120) ? 49 : 0;
    rx_idle_pct = (ticks_sent < 560) ? 49 : (ticks_sent < 1120) ? 13 : 0;
    while ($urandom_range(0, 99) < tx_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= raw;
    do @(posedge clk_i); while (!s_axis_tready);
    predicted = debounce_step(raw);
    pending_results.push_back(typed ? want : predicted);
    ticks_sent++;
  endtask

  task automatic send_run(input logic [KEY_W-1:0] keys, input int len);
    repeat (len) send_tick(keys, 1'b0, '0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_LONG_PRESS:    pr_long_thr  = val;
      CFG_SHORT_RELEASE: pr_short_max = val;
      CFG_COUNT_CEILING: pr_ceiling   = val;
      default: ;
    endcase
  endtask

  always @(posedge clk_i) begin : check_result
    result_t got;
    result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", '0, got.debounced_keys);
      end else begin
        want = pending_results.pop_front();
        if (got.debounced_keys != want.debounced_keys)
          report_mismatch("debounced_keys", want.debounced_keys, got.debounced_keys);
        if (got.short_release_events != want.short_release_events)
          report_mismatch("short_release_events", want.short_release_events,
                          got.short_release_events);
        if (got.long_press_events != want.long_press_events)
          report_mismatch("long_press_events", want.long_press_events,
                          got.long_press_events);
      end
      results_seen++;
    end
  end

  always @(posedge clk_i) begin
    m_axis_tready <= !rx_hold_off && ($urandom_range(0, 99) >= rx_idle_pct);
  end

  initial begin
    rx_hold_off = 1'b0;
    wait (ticks_sent >= 1200);
    @(posedge clk_i);
    rx_hold_off <= 1'b1;
    repeat (200) @(posedge clk_i);
    rx_hold_off <= 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin : stimulus
    reg_set_t         cur_set;
    logic [31:0]      rnd;
    logic [KEY_W-1:0] keys;
    logic [KEY_W-1:0] prev_keys;
    int               kind;
    int               sel;
    int               len;
    int               phase_start;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = '0;
    cfg_data_i    = '0;
    pr_phase      = DB_CAPTURE;
    pr_candidate  = '0;
    pr_confirmed  = '0;
    pr_held       = '0;
    for (int i = 0; i < NKEYS; i++) pr_count[i] = '0;
    pr_long_thr   = LONG_PRESS_RST;
    pr_short_max  = SHORT_RELEASE_RST;
    pr_ceiling    = COUNT_CEILING_RST;
    prev_keys     = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int k = 0; k < $size(DIRECTED); k++)
      send_tick(DIRECTED[k].raw, DIRECTED[k].typed, DIRECTED[k].want);

    for (int ph = 0; ph < 8; ph++) begin
      if (ph < 7) begin
        cur_set = REG_SETS[ph];
      end else begin
        cur_set.long_thr   = CNT_W'($urandom_range(2, 30));
        cur_set.short_max  = CNT_W'($urandom_range(2, 30));
        cur_set.ceiling    = CNT_W'($urandom_range(2, 40));
        cur_set.long_first = 1'b0;
      end
      s_axis_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clk_i);
      write_reg(CFG_LONG_PRESS, cur_set.long_thr);
      write_reg(CFG_SHORT_RELEASE, cur_set.short_max);
      write_reg(CFG_COUNT_CEILING, cur_set.ceiling);
      cfg_valid_i <= 1'b0;
      phase_start = ticks_sent;
      if (cur_set.long_first) begin
        keys = KEY_W'($urandom_range(1, 255));
        send_run(keys, 290);
        prev_keys = keys;
      end
      while (ticks_sent - phase_start < PHASE_TICKS) begin
        kind = $urandom_range(0, 99);
        rnd  = $urandom;
        if (kind < 12) begin
          repeat ($urandom_range(1, 4)) begin
            rnd = $urandom;
            send_tick(rnd[KEY_W-1:0], 1'b0, '0);
          end
        end else if (kind < 20) begin
          send_run(rnd[KEY_W-1:0], $urandom_range(1, 2));
        end else begin
          sel = $urandom_range(0, 99);
          if (sel < 50)      keys = prev_keys ^ (8'h01 << $urandom_range(0, 7));
          else if (sel < 60) keys = 8'h00;
          else if (sel < 65) keys = 8'hFF;
          else               keys = rnd[KEY_W-1:0];
          sel = $urandom_range(0, 99);
          if (sel < 65)      len = $urandom_range(3, 12);
          else if (sel < 90) len = $urandom_range(13, 60);
          else               len = $urandom_range(61, 280);
          if (len > PHASE_TICKS - (ticks_sent - phase_start))
            len = PHASE_TICKS - (ticks_sent - phase_start);
          send_run(keys, len);
          prev_keys = keys;
        end
      end
    end

    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+hdl
hdl/kdpe_pkg.sv
hdl/key_debounce_press_events_top.sv
hdl/kdpe_checker.sv
sim/key_debounce_press_events_top_test.sv
